// ===== design/rct_pkg.sv =====
`timescale 1ns / 1ps

package rct_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_ADDED    = 2'd0,
    STATUS_CONFLICT = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_CLEARED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
  } in_req_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] stored_count;
  } out_rsp_t;

  // Search token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic             hit;
    logic             free_found;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } tok_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } cell_cmd_t;

endpackage

// ===== design/range_conflict_table_unit.sv =====
`timescale 1ns / 1ps
// An insert request's search token visits one cell per cycle along the chain, and the result is
// formed once the token leaves the last cell; a clear request needs no search.
// The unit takes one request at a time.
// A stalled result holds the unit in its final state and delays the next request by the stall.
// Reset: all entries become invalid, the count goes to zero and no result is pending.
// Range storage itself is not cleared and is only read behind its valid bit.

module range_conflict_table_unit
  import rct_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_RANGES);
  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  out_rsp_t         res_q, res_d;
  out_rsp_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;
  tok_t             inj_q, inj_d;
  cell_cmd_t        cmd;
  logic [IdxW-1:0]  wr_sel;
  logic             accept;

  tok_t             tok_chain [MAX_RANGES+1];
  logic [IdxW-1:0]  idx_chain [MAX_RANGES+1];
  tok_t             last_tok;

  assign tok_chain[0] = inj_q;
  assign idx_chain[0] = '0;
  assign last_tok     = tok_chain[MAX_RANGES];

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    rct_cell #(
      .IDX_W (IdxW),
      .IDX   (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_chain[g]),
      .idx_i    (idx_chain[g]),
      .tok_o    (tok_chain[g+1]),
      .idx_o    (idx_chain[g+1]),
      .cmd_i    (cmd),
      .wr_sel_i (wr_sel)
    );
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    inj_d       = inj_q;
    inj_d.active = 1'b0;
    cmd.clear   = 1'b0;
    cmd.wr_en   = 1'b0;
    cmd.lo      = last_tok.lo;
    cmd.hi      = last_tok.hi;
    wr_sel      = idx_chain[MAX_RANGES];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.op == OP_CLEAR) begin
            cmd.clear          = 1'b1;
            count_d            = '0;
            res_d.status       = STATUS_CLEARED;
            res_d.stored_count = '0;
            state_d            = ST_DONE;
          end else begin
            inj_d.active     = 1'b1;
            inj_d.hit        = 1'b0;
            inj_d.free_found = 1'b0;
            inj_d.lo         = in_req_i.range_start;
            inj_d.hi         = in_req_i.range_end;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_tok.active) begin
          state_d = ST_DONE;
          if (last_tok.hit) begin
            res_d.status       = STATUS_CONFLICT;
            res_d.stored_count = CountW'(count_q);
          end else if (!last_tok.free_found) begin
            res_d.status       = STATUS_FULL;
            res_d.stored_count = CountW'(count_q);
          end else begin
            cmd.wr_en          = 1'b1;
            count_d            = count_q + CntW'(1);
            res_d.status       = STATUS_ADDED;
            res_d.stored_count = CountW'(count_d);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      inj_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      inj_q       <= inj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== design/rct_cell.sv =====
`timescale 1ns / 1ps

module rct_cell
  import rct_pkg::*;
#(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] idx_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] idx_o,
  input  cell_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] wr_sel_i
);

  logic [AddrW-1:0] lo_q, hi_q;
  logic             valid_q;
  tok_t             tok_d, tok_q;
  logic [IDX_W-1:0] idx_d, idx_q;
  logic             ovl;
  logic             sel;

  assign sel = (wr_sel_i == IDX_W'(IDX));

  assign ovl = (tok_i.lo >= lo_q && tok_i.lo <= hi_q) ||
               (tok_i.hi >= lo_q && tok_i.hi <= hi_q) ||
               (tok_i.lo <  lo_q && tok_i.hi >  hi_q);

  always_comb begin
    tok_d            = tok_i;
    tok_d.hit        = tok_i.hit | (valid_q & ovl);
    tok_d.free_found = tok_i.free_found | ~valid_q;
    // The first free cell along the chain claims the slot.
    idx_d = (tok_i.free_found || valid_q) ? idx_i : IDX_W'(IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (cmd_i.clear) begin
        valid_q <= 1'b0;
      end else if (cmd_i.wr_en && sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.wr_en && sel) begin
      lo_q <= cmd_i.lo;
      hi_q <= cmd_i.hi;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

// ===== tb/range_conflict_table_unit_tb.sv =====
`timescale 1ns / 1ps

module range_conflict_table_unit_tb;
  import rct_pkg::*;

  localparam int unsigned MaxRanges  = 64;
  localparam int unsigned DrainWait  = MaxRanges + 8;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [AddrW-1:0] AddrMax = '1;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_rsp_t out_rsp_o;

  range_conflict_table_unit #(
    .MAX_RANGES(MaxRanges)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Shadow copy of the range table.
  logic [AddrW-1:0] shadow_lo [MaxRanges];
  logic [AddrW-1:0] shadow_hi [MaxRanges];
  bit               shadow_used [MaxRanges];
  int unsigned      shadow_count;

  out_rsp_t    table_reply_q[$];
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  bit          req_gaps_on;
  bit          rsp_stalls_on;
  logic [AddrW-1:0] window_base;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit ranges_collide(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi,
                                        input logic [AddrW-1:0] slo,
                                        input logic [AddrW-1:0] shi);
    return (lo >= slo && lo <= shi) || (hi >= slo && hi <= shi) || (lo < slo && hi > shi);
  endfunction

  function automatic out_rsp_t apply_range_op(input in_req_t req);
    out_rsp_t    rsp;
    bit          hit;
    int          free_slot;
    free_slot = -1;
    hit = 1'b0;
    if (req.op == OP_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_count = 0;
      rsp.status = STATUS_CLEARED;
    end else begin
      for (int i = 0; i < MaxRanges; i++) begin
        if (shadow_used[i]) begin
          if (ranges_collide(req.range_start, req.range_end, shadow_lo[i], shadow_hi[i]))
            hit = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit) begin
        rsp.status = STATUS_CONFLICT;
      end else if (free_slot < 0) begin
        rsp.status = STATUS_FULL;
      end else begin
        shadow_lo[free_slot]   = req.range_start;
        shadow_hi[free_slot]   = req.range_end;
        shadow_used[free_slot] = 1'b1;
        shadow_count++;
        rsp.status = STATUS_ADDED;
      end
    end
    rsp.stored_count = CountW'(shadow_count);
    return rsp;
  endfunction

  // Called just after a falling edge; returns just after a falling edge with valid still high.
  task automatic send_req(input op_e op, input logic [AddrW-1:0] lo,
                          input logic [AddrW-1:0] hi);
    in_req_t req;
    req.op          = op;
    req.range_start = lo;
    req.range_end   = hi;
    if (req_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_reply_q.push_back(apply_range_op(req));
    @(negedge clk_i);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (table_reply_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_req_t random_range_req();
    in_req_t          req;
    int unsigned      pick;
    logic [AddrW-1:0] lo;
    pick = $urandom_range(0, 99);
    lo   = window_base + AddrW'($urandom_range(0, 1023));
    req.op          = OP_INSERT;
    req.range_start = lo;
    req.range_end   = lo + AddrW'($urandom_range(0, 15));
    if (pick < 2) begin
      req.op          = OP_CLEAR;
      req.range_start = {$urandom, $urandom};
      req.range_end   = {$urandom, $urandom};
      window_base     = {$urandom, $urandom};
    end else if (pick < 7) begin
      req.range_start = {$urandom, $urandom};
      req.range_end   = {$urandom, $urandom};
    end else if (pick < 12) begin
      // Inverted range that starts inside the window.
      req.range_end = lo - AddrW'($urandom_range(1, 15));
    end
    return req;
  endfunction

  task automatic test_overlap_cases();
    send_req(OP_CLEAR, AddrMax, AddrMax);
    send_req(OP_INSERT, '0, '0);
    send_req(OP_INSERT, AddrMax, AddrMax);
    send_req(OP_INSERT, '0, '0);
    send_req(OP_INSERT, 64'd5, 64'd10);
    send_req(OP_INSERT, 64'd3, 64'd5);
    send_req(OP_INSERT, 64'd10, 64'd12);
    send_req(OP_INSERT, 64'd4, 64'd11);
    send_req(OP_INSERT, 64'd6, 64'd9);
    send_req(OP_INSERT, 64'd11, 64'd20);
    send_req(OP_INSERT, 64'd100, 64'd50);
    send_req(OP_INSERT, 64'd60, 64'd70);
    send_req(OP_INSERT, 64'd30, 64'd40);
    send_req(OP_INSERT, '0, AddrMax);
    send_req(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_req(OP_INSERT, AddrMax - 1, 64'd1);
    send_req(OP_CLEAR, '0, '0);
    send_req(OP_CLEAR, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(OP_INSERT, AddrMax - 1, AddrMax);
  endtask

  // Fills every entry with disjoint ranges, then tries one more, an overlap, an inverted one.
  task automatic test_fill_to_capacity();
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] lo;
    base = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000;
    send_req(OP_CLEAR, '0, '0);
    for (int i = 0; i < MaxRanges; i++) begin
      lo = base + AddrW'(i * 64 + $urandom_range(0, 31));
      send_req(OP_INSERT, lo, lo + AddrW'($urandom_range(0, 31)));
    end
    lo = base + AddrW'(MaxRanges * 64);
    send_req(OP_INSERT, lo, lo + 64'd5);
    send_req(OP_INSERT, base, lo - 1);
    send_req(OP_INSERT, lo + 64'd100, lo + 64'd90);
    send_req(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_ranges(input int unsigned count);
    in_req_t req;
    for (int unsigned n = 0; n < count; n++) begin
      req = random_range_req();
      send_req(req.op, req.range_start, req.range_end);
      // Let the table go fully quiet now and then before the next request.
      if (n % 200 == 199) drain_replies();
    end
  endtask

  task automatic test_back_to_back();
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    test_random_ranges(150);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    error_cnt     = 0;
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    window_base   = {$urandom, $urandom};
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    shadow_count = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_overlap_cases();
    test_fill_to_capacity();
    test_random_ranges(1050);
    test_fill_to_capacity();
    test_back_to_back();

    drain_replies();
    repeat (DrainWait) @(posedge clk_i);
    if (table_reply_q.size() != 0) begin
      $error("%0d replies never arrived", table_reply_q.size());
      error_cnt++;
    end
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_stalls_on && $urandom_range(0, 15) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (table_reply_q.size() == 0) begin
        $error("reply with no request pending: status %0d stored_count %0d",
               out_rsp_o.status, out_rsp_o.stored_count);
        error_cnt++;
      end else begin
        want = table_reply_q.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_rsp_o.status);
          error_cnt++;
        end
        if (out_rsp_o.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d actual %0d", want.stored_count,
                 out_rsp_o.stored_count);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
